// File: rtl/sqm_pkg.sv
// Package for the stack/queue operation unit.
// Holds the transfer payload types, action and status codes, and the controller state type.
// No dependencies.
package sqm_pkg;

  // Action codes carried in the input transfer.
  localparam logic [2:0] ACT_PUSH = 3'd0;
  localparam logic [2:0] ACT_LIST = 3'd1;
  localparam logic [2:0] ACT_PEEK = 3'd2;
  localparam logic [2:0] ACT_POP  = 3'd3;
  localparam logic [2:0] ACT_SWAP = 3'd4;

  // Status codes carried in the output transfer.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_PEEK_EMPTY = 3'd1;
  localparam logic [2:0] ST_POP_EMPTY  = 3'd2;
  localparam logic [2:0] ST_SWAP_SHORT = 3'd3;
  localparam logic [2:0] ST_FULL       = 3'd4;
  localparam logic [2:0] ST_HALTED     = 3'd5;

  // Input transfer payload.
  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] push_value;
  } in_t;

  // Output transfer payload.
  typedef struct packed {
    logic signed [31:0] result_value;
    logic               has_value;
    logic [2:0]         status;
    logic               last_result;
  } out_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_PEEK,
    S_LIST,
    S_SWAP_B,
    S_SWAP_WA,
    S_SWAP_WB
  } state_e;

endpackage

// File: rtl/sqm_ram.sv
// Generic simple dual-port RAM: one write port and one read port with registered read data.
// Used for the entry store of the stack/queue unit. No dependencies.
module sqm_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/stack_queue_machine.sv
// Push, pop, swap and error items load their result into the output register when taken;
// a peek reads the top entry first (S_PEEK). A list reads the top entry, then emits one
// entry per cycle while the output is not stalled. Items are taken only in idle with the
// output free; a swap steps through S_SWAP_B, S_SWAP_WA and S_SWAP_WB (two reads, two writes).
// Reset clears the pointer, count, halt, mode and output valid; the entry store is not cleared.
module stack_queue_machine
  import sqm_pkg::*;
#(
  parameter int STORE_DEPTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic cfg_data_i
);

  localparam int PW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam logic [CW:0]   DEPTH_W = (CW + 1)'(STORE_DEPTH);
  localparam logic [PW-1:0] LAST_SLOT = PW'(STORE_DEPTH - 1);

  // Ring addition of a slot and an offset below the depth.
  function automatic logic [PW-1:0] wrap_add(logic [PW-1:0] a, logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW + 1)'(a) + (CW + 1)'(b);
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[PW-1:0];
  endfunction

  state_e        state_q, state_d;
  logic [PW-1:0] top_q, top_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          halted_q, halted_d;
  logic          mode_q;
  logic          out_valid_q;
  out_t          out_data_q;
  logic [CW-1:0] list_idx_q, list_idx_d;
  logic [PW-1:0] list_addr_q, list_addr_d;
  logic [31:0]   swap_tmp_q, swap_tmp_d;

  logic          out_free, accept;
  logic          empty, full, short;
  logic [PW-1:0] top_inc, top_dec, tail, list_next;
  logic          last_entry;
  logic          mem_we, mem_re;
  logic [PW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_wdata, mem_rdata;
  logic          out_load;
  out_t          res;

  sqm_ram #(
    .Width(32),
    .Depth(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Handshake and store status.
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE) && out_free;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign empty = (cnt_q == '0);
  assign full  = (cnt_q == CW'(STORE_DEPTH));
  assign short = (cnt_q < CW'(2));

  // Ring slot arithmetic.
  assign top_inc    = (top_q == LAST_SLOT) ? '0 : top_q + 1'b1;
  assign top_dec    = (top_q == '0) ? LAST_SLOT : top_q - 1'b1;
  assign tail       = wrap_add(top_q, cnt_q);
  assign list_next  = (list_addr_q == LAST_SLOT) ? '0 : list_addr_q + 1'b1;
  assign last_entry = ((list_idx_q + 1'b1) == cnt_q);

  // Next state. Items are only taken in idle, so a read never overlaps a pending write.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && !halted_q) begin
          if (in_data_i.action == ACT_LIST && !empty) begin
            state_d = S_LIST;
          end else if (in_data_i.action == ACT_PEEK && !empty) begin
            state_d = S_PEEK;
          end else if (in_data_i.action == ACT_SWAP && !short) begin
            state_d = S_SWAP_B;
          end
        end
      end
      S_PEEK: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_LIST: begin
        if (out_free && last_entry) begin
          state_d = S_IDLE;
        end
      end
      S_SWAP_B:  state_d = S_SWAP_WA;
      S_SWAP_WA: state_d = S_SWAP_WB;
      S_SWAP_WB: state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Datapath control: store accesses, pointer updates and result formation.
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = top_q;
    mem_wdata   = in_data_i.push_value;
    mem_re      = 1'b0;
    mem_raddr   = top_q;
    out_load    = 1'b0;
    res         = '0;
    res.last_result = 1'b1;
    top_d       = top_q;
    cnt_d       = cnt_q;
    halted_d    = halted_q;
    list_idx_d  = list_idx_q;
    list_addr_d = list_addr_q;
    swap_tmp_d  = swap_tmp_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (halted_q) begin
            res.status = ST_HALTED;
            out_load   = 1'b1;
          end else begin
            case (in_data_i.action)
              ACT_PUSH: begin
                out_load = 1'b1;
                if (full) begin
                  res.status = ST_FULL;
                  halted_d   = 1'b1;
                end else begin
                  mem_we = 1'b1;
                  if (!mode_q) begin
                    top_d     = top_dec;
                    mem_waddr = top_dec;
                  end else begin
                    mem_waddr = tail;
                  end
                  cnt_d = cnt_q + 1'b1;
                end
              end
              ACT_LIST: begin
                if (empty) begin
                  out_load = 1'b1;
                end else begin
                  mem_re      = 1'b1;
                  list_idx_d  = '0;
                  list_addr_d = top_q;
                end
              end
              ACT_PEEK: begin
                if (empty) begin
                  res.status = ST_PEEK_EMPTY;
                  halted_d   = 1'b1;
                  out_load   = 1'b1;
                end else begin
                  mem_re = 1'b1;
                end
              end
              ACT_POP: begin
                out_load = 1'b1;
                if (empty) begin
                  res.status = ST_POP_EMPTY;
                  halted_d   = 1'b1;
                end else begin
                  top_d = top_inc;
                  cnt_d = cnt_q - 1'b1;
                end
              end
              ACT_SWAP: begin
                out_load = 1'b1;
                if (short) begin
                  res.status = ST_SWAP_SHORT;
                  halted_d   = 1'b1;
                end else begin
                  mem_re = 1'b1;
                end
              end
              default: begin
                out_load = 1'b1;
              end
            endcase
          end
        end
      end
      S_PEEK: begin
        if (out_free) begin
          res.result_value = mem_rdata;
          res.has_value    = 1'b1;
          out_load         = 1'b1;
        end
      end
      S_LIST: begin
        // Emit the entry last read from the store and fetch the next one in the same cycle.
        if (out_free) begin
          res.result_value = mem_rdata;
          res.has_value    = 1'b1;
          res.last_result  = last_entry;
          out_load         = 1'b1;
          if (!last_entry) begin
            mem_re      = 1'b1;
            mem_raddr   = list_next;
            list_addr_d = list_next;
            list_idx_d  = list_idx_q + 1'b1;
          end
        end
      end
      S_SWAP_B: begin
        swap_tmp_d = mem_rdata;
        mem_re     = 1'b1;
        mem_raddr  = top_inc;
      end
      S_SWAP_WA: begin
        mem_we    = 1'b1;
        mem_waddr = top_q;
        mem_wdata = mem_rdata;
      end
      S_SWAP_WB: begin
        mem_we    = 1'b1;
        mem_waddr = top_inc;
        mem_wdata = swap_tmp_q;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      top_q       <= '0;
      cnt_q       <= '0;
      halted_q    <= 1'b0;
      mode_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      top_q    <= top_d;
      cnt_q    <= cnt_d;
      halted_q <= halted_d;
      if (cfg_valid_i) begin
        mode_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= res;
    end
    list_idx_q  <= list_idx_d;
    list_addr_q <= list_addr_d;
    swap_tmp_q  <= swap_tmp_d;
  end

`ifndef SYNTHESIS
  // The fill count never passes the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(STORE_DEPTH))
    else $error("entry count beyond store depth");

  // Once latched, the halt stays until reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni) halted_q |=> halted_q)
    else $error("halt cleared without reset");

  // A listing only runs over a non-empty store.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (state_q == S_LIST) |-> !empty)
    else $error("listing an empty store");

  // A new result is never loaded over one that waits to be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !out_load)
    else $error("output overwritten while stalled");
`endif

endmodule

// File: dv/stack_queue_machine_tb.sv
// Self-checking testbench for the stack/queue operation unit, stack_queue_machine.
// Depends on sqm_pkg for the transfer payload types and the action and status codes.
module stack_queue_machine_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sqm_pkg::*;

  localparam int DEPTH = 32;

  // Action codes the block does not define; each one must answer ok and change nothing.
  localparam logic [2:0] ACT_UNDEF_LO  = 3'd5;
  localparam logic [2:0] ACT_UNDEF_MID = 3'd6;
  localparam logic [2:0] ACT_UNDEF_HI  = 3'd7;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  // Closing error cases, one of which ends each run.
  localparam int ERR_FULL       = 0;
  localparam int ERR_PEEK_EMPTY = 1;
  localparam int ERR_POP_EMPTY  = 2;
  localparam int ERR_SWAP_SHORT = 3;

  // Plain ok answer with no entry.
  localparam out_t R_OK = '{32'sd0, 1'b0, ST_OK, 1'b1};

  typedef struct packed {
    in_t  item;
    logic fixed;
    out_t want;
  } dir_row_t;

  // Directed rows, stack mode from reset. Rows with fixed low take their answer from the
  // predictor.
  localparam dir_row_t DIRECTED [25] = '{
    '{'{ACT_LIST,      32'sd0},        1'b1, R_OK},
    '{'{ACT_UNDEF_LO,  VAL_MAX},       1'b1, R_OK},
    '{'{ACT_UNDEF_HI,  VAL_MIN},       1'b1, R_OK},
    '{'{ACT_PUSH,      VAL_MIN},       1'b1, R_OK},
    '{'{ACT_PUSH,      VAL_MAX},       1'b1, R_OK},
    '{'{ACT_PEEK,      32'sd0},        1'b1, '{VAL_MAX, 1'b1, ST_OK, 1'b1}},
    '{'{ACT_SWAP,      32'sd0},        1'b1, R_OK},
    '{'{ACT_PEEK,      -32'sd1},       1'b1, '{VAL_MIN, 1'b1, ST_OK, 1'b1}},
    '{'{ACT_LIST,      32'sd0},        1'b0, R_OK},
    '{'{ACT_PUSH,      32'sd0},        1'b1, R_OK},
    '{'{ACT_PUSH,      -32'sd1},       1'b1, R_OK},
    '{'{ACT_PUSH,      32'sh5555_5555}, 1'b1, R_OK},
    '{'{ACT_PUSH,      32'shaaaa_aaaa}, 1'b1, R_OK},
    '{'{ACT_SWAP,      32'sd0},        1'b1, R_OK},
    '{'{ACT_LIST,      32'sd0},        1'b0, R_OK},
    '{'{ACT_POP,       32'sd0},        1'b1, R_OK},
    '{'{ACT_PEEK,      32'sd0},        1'b0, R_OK},
    '{'{ACT_POP,       32'sd0},        1'b1, R_OK},
    '{'{ACT_SWAP,      32'sd0},        1'b1, R_OK},
    '{'{ACT_LIST,      32'sd0},        1'b0, R_OK},
    '{'{ACT_UNDEF_MID, 32'sd0},        1'b1, R_OK},
    '{'{ACT_POP,       32'sd0},        1'b1, R_OK},
    '{'{ACT_POP,       32'sd0},        1'b1, R_OK},
    '{'{ACT_POP,       32'sd0},        1'b1, R_OK},
    '{'{ACT_LIST,      32'sd0},        1'b0, R_OK}
  };

  logic clk_i     = 1'b0;
  logic rst_ni    = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_ready = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_data  = 1'b0;
  logic in_ready;
  logic out_valid;
  logic cfg_ready;
  out_t out_data;

  // Shadow copy of the unit's state.
  logic signed [31:0] shadow_store [DEPTH];
  int   shadow_top        = 0;
  int   shadow_count      = 0;
  bit   shadow_halt       = 1'b0;
  bit   shadow_queue_mode = 1'b0;

  out_t step_results [$];
  out_t owed_results [$];
  bit   idle_on      = 1'b1;
  int   stall_left   = 0;
  int   mismatches   = 0;
  int   items_sent   = 0;
  int   results_seen = 0;

  // Random phases: mode, item count, push weight and whether idling is on.
  int    phase_mode [4]  = '{1, 0, 1, 0};
  int    phase_items [4] = '{120, 120, 110, 100};
  int    phase_push [4]  = '{45, 22, 45, 30};
  bit    phase_idle [4]  = '{1, 1, 1, 0};
  string err_names [4]   = '{"push when full", "peek on empty", "pop on empty",
                             "swap with fewer than two entries"};

  stack_queue_machine #(
    .STORE_DEPTH(DEPTH)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  // 20 ns clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic out_t mk_result(logic signed [31:0] v, logic has, logic [2:0] st,
                                     logic last);
    out_t r;
    r.result_value = v;
    r.has_value    = has;
    r.status       = st;
    r.last_result  = last;
    return r;
  endfunction

  function automatic in_t mk_item(logic [2:0] act, logic signed [31:0] v);
    in_t it;
    it.action     = act;
    it.push_value = v;
    return it;
  endfunction

  // Applies one operation to the shadow state and leaves its answers in step_results.
  task automatic apply_action(input in_t item);
    int slot;
    step_results = {};
    if (shadow_halt) begin
      step_results.push_back(mk_result(32'sd0, 1'b0, ST_HALTED, 1'b1));
      return;
    end
    case (item.action)
      ACT_PUSH: begin
        if (shadow_count >= DEPTH) begin
          shadow_halt = 1'b1;
          step_results.push_back(mk_result(32'sd0, 1'b0, ST_FULL, 1'b1));
          return;
        end
        // Stack mode grows a new top; queue mode appends below the bottom.
        if (!shadow_queue_mode) begin
          shadow_top = (shadow_top + DEPTH - 1) % DEPTH;
          slot = shadow_top;
        end else begin
          slot = (shadow_top + shadow_count) % DEPTH;
        end
        shadow_store[slot] = item.push_value;
        shadow_count++;
      end
      ACT_LIST: begin
        if (shadow_count > 0) begin
          for (int i = 0; i < shadow_count; i++) begin
            step_results.push_back(mk_result(shadow_store[(shadow_top + i) % DEPTH], 1'b1,
                                             ST_OK, i == shadow_count - 1));
          end
          return;
        end
      end
      ACT_PEEK: begin
        if (shadow_count == 0) begin
          shadow_halt = 1'b1;
          step_results.push_back(mk_result(32'sd0, 1'b0, ST_PEEK_EMPTY, 1'b1));
        end else begin
          step_results.push_back(mk_result(shadow_store[shadow_top], 1'b1, ST_OK, 1'b1));
        end
        return;
      end
      ACT_POP: begin
        if (shadow_count == 0) begin
          shadow_halt = 1'b1;
          step_results.push_back(mk_result(32'sd0, 1'b0, ST_POP_EMPTY, 1'b1));
          return;
        end
        shadow_top = (shadow_top + 1) % DEPTH;
        shadow_count--;
      end
      ACT_SWAP: begin
        logic signed [31:0] held;
        if (shadow_count < 2) begin
          shadow_halt = 1'b1;
          step_results.push_back(mk_result(32'sd0, 1'b0, ST_SWAP_SHORT, 1'b1));
          return;
        end
        slot = (shadow_top + 1) % DEPTH;
        held = shadow_store[shadow_top];
        shadow_store[shadow_top] = shadow_store[slot];
        shadow_store[slot] = held;
      end
      default: begin
      end
    endcase
    step_results.push_back(R_OK);
  endtask

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // Sends one operation, waits for its transfer, then books the answers it owes.
  task automatic drive_item(input in_t item, input bit use_fixed, input out_t fixed_res);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk_i); while (!in_ready);
    items_sent++;
    apply_action(item);
    if (use_fixed) owed_results.push_back(fixed_res);
    else foreach (step_results[k]) owed_results.push_back(step_results[k]);
  endtask

  // Drops the input valid and waits until every owed answer has arrived.
  task automatic settle();
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_mode(input bit mode);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_queue_mode = mode;
  endtask

  // Picks a legal operation so the run never halts before its closing error.
  task automatic random_item(input int push_weight, output in_t item);
    int r;
    case ($urandom_range(0, 15))
      0:       item.push_value = VAL_MIN;
      1:       item.push_value = VAL_MAX;
      2:       item.push_value = 32'sd0;
      3:       item.push_value = -32'sd1;
      default: item.push_value = $urandom;
    endcase
    r = $urandom_range(0, 99);
    if (r < 3)                     item.action = ACT_UNDEF_LO + 3'($urandom_range(0, 2));
    else if (r < 9)                item.action = ACT_LIST;
    else if (r < 21)               item.action = ACT_PEEK;
    else if (r < 33)               item.action = ACT_SWAP;
    else if (r < 33 + push_weight) item.action = ACT_PUSH;
    else                           item.action = ACT_POP;
    if (item.action == ACT_PUSH && shadow_count >= DEPTH) item.action = ACT_POP;
    else if ((item.action == ACT_POP || item.action == ACT_PEEK) && shadow_count == 0)
      item.action = ACT_PUSH;
    else if (item.action == ACT_SWAP && shadow_count < 2) item.action = ACT_PUSH;
  endtask

  // Receiver drops out_ready in bursts of random length while idling is enabled.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compares every output transfer with the oldest owed answer.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid && out_ready) begin
      results_seen++;
      if (owed_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result %h", out_data));
      end else begin
        want = owed_results.pop_front();
        if (out_data.result_value !== want.result_value)
          flag_mismatch($sformatf("result_value %h, wanted %h", out_data.result_value,
                                  want.result_value));
        if (out_data.has_value !== want.has_value)
          flag_mismatch($sformatf("has_value %b, wanted %b", out_data.has_value,
                                  want.has_value));
        if (out_data.status !== want.status)
          flag_mismatch($sformatf("status %0d, wanted %0d", out_data.status, want.status));
        if (out_data.last_result !== want.last_result)
          flag_mismatch($sformatf("last_result %b, wanted %b", out_data.last_result,
                                  want.last_result));
      end
    end
  end

  // Main sequence: reset, directed rows, random phases in both modes, closing error, halted answers.
  initial begin
    in_t  item;
    int   err_kind;
    int   floor_count;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_mode(1'b0);

    foreach (DIRECTED[i]) drive_item(DIRECTED[i].item, DIRECTED[i].fixed, DIRECTED[i].want);

    for (int p = 0; p < 4; p++) begin
      settle();
      write_mode(phase_mode[p][0]);
      idle_on = phase_idle[p];
      repeat (phase_items[p]) begin
        random_item(phase_push[p], item);
        drive_item(item, 1'b0, R_OK);
      end
    end

    // One error per run, since only reset clears the halt.
    err_kind = $urandom_range(ERR_FULL, ERR_SWAP_SHORT);
    case (err_kind)
      ERR_FULL: begin
        while (shadow_count < DEPTH) drive_item(mk_item(ACT_PUSH, $urandom), 1'b0, R_OK);
        drive_item(mk_item(ACT_PUSH, $urandom), 1'b1, '{32'sd0, 1'b0, ST_FULL, 1'b1});
      end
      ERR_PEEK_EMPTY: begin
        while (shadow_count > 0) drive_item(mk_item(ACT_POP, $urandom), 1'b0, R_OK);
        drive_item(mk_item(ACT_PEEK, $urandom), 1'b1, '{32'sd0, 1'b0, ST_PEEK_EMPTY, 1'b1});
      end
      ERR_POP_EMPTY: begin
        while (shadow_count > 0) drive_item(mk_item(ACT_POP, $urandom), 1'b0, R_OK);
        drive_item(mk_item(ACT_POP, $urandom), 1'b1, '{32'sd0, 1'b0, ST_POP_EMPTY, 1'b1});
      end
      default: begin
        floor_count = $urandom_range(0, 1);
        while (shadow_count > floor_count) drive_item(mk_item(ACT_POP, $urandom), 1'b0, R_OK);
        while (shadow_count < floor_count) drive_item(mk_item(ACT_PUSH, $urandom), 1'b0, R_OK);
        drive_item(mk_item(ACT_SWAP, $urandom), 1'b1, '{32'sd0, 1'b0, ST_SWAP_SHORT, 1'b1});
      end
    endcase

    // After the halt every operation, list included, must answer halted.
    repeat (6) drive_item(mk_item(3'($urandom_range(0, 7)), $urandom), 1'b0, R_OK);
    settle();

    $display("Run covered %0d operation transfers and %0d result transfers %s",
             items_sent, results_seen, "in stack and queue mode.");
    $display("It closed on %s, then checked the halted answers.", err_names[err_kind]);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
